/* sv/bgpd_pkg.sv */
// Shared types and constants of the BMP gray pixel decoder.
package bgpd_pkg;

  localparam int IMG_SIDE_DEF  = 28;
  localparam int PAL_DEPTH_DEF = 256;
  localparam int QDEPTH        = 4;

  localparam logic [15:0] BMP_SIG  = 16'h4D42;
  localparam int          HDR_LAST = 53;
  localparam int          PIX_BASE = 54;
  localparam int          MIN_INFO = 40;

  localparam logic [21:0] LUMA_R   = 22'd13933;
  localparam logic [23:0] LUMA_G   = 24'd46871;
  localparam logic [20:0] LUMA_B   = 21'd4732;
  localparam logic [24:0] LUMA_RND = 25'd32768;

  localparam logic [3:0] ST_PIXEL     = 4'd0;
  localparam logic [3:0] ST_NOT_BM    = 4'd1;
  localparam logic [3:0] ST_HDR_SMALL = 4'd2;
  localparam logic [3:0] ST_PLANES    = 4'd3;
  localparam logic [3:0] ST_COMP      = 4'd4;
  localparam logic [3:0] ST_SIZE      = 4'd5;
  localparam logic [3:0] ST_DEPTH     = 4'd6;
  localparam logic [3:0] ST_OFFSET    = 4'd7;
  localparam logic [3:0] ST_TRUNC     = 4'd8;

  typedef enum logic [1:0] {
    K_STATUS = 2'd0,
    K_PALWR  = 2'd1,
    K_PIX8   = 2'd2,
    K_PIX24  = 2'd3
  } kind_t;

  // d0/d1/d2: index or byte / palette address or green / red
  typedef struct packed {
    kind_t       kind;
    logic [3:0]  status;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [7:0]  d2;
    logic [1:0]  lane;
    logic        use_pal;
    logic [4:0]  row;
    logic [4:0]  col;
    logic        last;
  } item_t;

endpackage

/* sv/bgpd_front.sv */
// Byte parser: header checks, palette capture and pixel classification.
module bgpd_front #(
  parameter int IMG_SIDE      = bgpd_pkg::IMG_SIDE_DEF,
  parameter int PALETTE_DEPTH = bgpd_pkg::PAL_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [7:0]       data_byte,
  input  logic             first_byte,
  input  logic             end_of_file,
  output logic             push,
  output bgpd_pkg::item_t  item
);

  localparam int RW       = $clog2(IMG_SIDE + 1);
  localparam int CW       = $clog2(PALETTE_DEPTH + 1);
  localparam int RAW8     = IMG_SIDE;
  localparam int RAW24    = IMG_SIDE * 3;
  localparam int STRIDE8  = (RAW8 + 3) / 4 * 4;
  localparam int STRIDE24 = (RAW24 + 3) / 4 * 4;
  localparam int PW       = $clog2(STRIDE24 + 1);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SKIP   = 4'b0010,
    PH_PIXELS = 4'b0100,
    PH_IDLE   = 4'b1000
  } phase_t;

  phase_t          phase_r, phase_nxt, cur_phase;
  logic [31:0]     boff_r, boff_nxt, cur_boff;
  logic [31:0]     off_r, info_r, width_r, height_r, comp_r, colors_r;
  logic [15:0]     planes_r, bpp_r;
  logic [CW-1:0]   pcnt_r, pcnt_nxt;
  logic [PW-1:0]   pos_r, pos_nxt, cur_pos, pos_inc;
  logic [RW-1:0]   row_r, row_nxt, cur_row, col_r, col_nxt, cur_col, orow;
  logic [1:0]      lane_r, lane_nxt, cur_lane;
  logic [15:0]     bg_r, bg_nxt;
  logic            bpp24_r, bpp24_nxt, bup_r, bup_nxt;
  logic [3:0]      hdr_err, err;
  logic            pix, palwr, pix_last;
  logic [31:0]     diff, nq, n32, p;
  bgpd_pkg::item_t pix_item;

  always_comb begin
    cur_phase = first_byte ? PH_HEADER : phase_r;
    cur_boff  = first_byte ? 32'd0 : boff_r;
    cur_pos   = first_byte ? '0 : pos_r;
    cur_row   = first_byte ? '0 : row_r;
    cur_col   = first_byte ? '0 : col_r;
    cur_lane  = first_byte ? 2'd0 : lane_r;
  end

  // Checks done once the whole fixed header has arrived
  always_comb begin
    priority if (planes_r != 16'd1) hdr_err = bgpd_pkg::ST_PLANES;
    else if (comp_r != 32'd0) hdr_err = bgpd_pkg::ST_COMP;
    else if (width_r != 32'(IMG_SIDE) ||
             (height_r != 32'(IMG_SIDE) && height_r != 32'd0 - 32'(IMG_SIDE)))
      hdr_err = bgpd_pkg::ST_SIZE;
    else if (bpp_r != 16'd8 && bpp_r != 16'd24) hdr_err = bgpd_pkg::ST_DEPTH;
    else if ((bpp_r == 16'd8 && off_r <= 32'(bgpd_pkg::PIX_BASE)) ||
             (bpp_r == 16'd24 && off_r < 32'(bgpd_pkg::PIX_BASE)))
      hdr_err = bgpd_pkg::ST_OFFSET;
    else hdr_err = bgpd_pkg::ST_PIXEL;
  end

  always_comb begin
    diff = off_r - 32'(bgpd_pkg::PIX_BASE);
    nq   = {2'b00, diff[31:2]};
    n32  = (colors_r != 32'd0 && colors_r < nq) ? colors_r : nq;
    if (n32 > 32'(PALETTE_DEPTH)) n32 = 32'(PALETTE_DEPTH);
    p    = cur_boff - 32'(bgpd_pkg::PIX_BASE);
  end

  assign pos_inc  = PW'(cur_pos + 1'b1);
  assign orow     = bup_r ? RW'(IMG_SIDE - 1) - cur_row : cur_row;
  assign pix_last = (cur_row == RW'(IMG_SIDE - 1)) && (cur_col == RW'(IMG_SIDE - 1));

  always_comb begin
    phase_nxt = cur_phase;
    boff_nxt  = cur_boff;
    pos_nxt   = cur_pos;
    row_nxt   = cur_row;
    col_nxt   = cur_col;
    lane_nxt  = cur_lane;
    bg_nxt    = bg_r;
    pcnt_nxt  = pcnt_r;
    bpp24_nxt = bpp24_r;
    bup_nxt   = bup_r;
    err       = bgpd_pkg::ST_PIXEL;
    pix       = 1'b0;
    palwr     = 1'b0;
    pix_item  = '0;
    pix_item.row  = 5'(orow);
    pix_item.col  = 5'(cur_col);
    pix_item.last = pix_last;
    unique case (cur_phase)
      PH_HEADER: begin
        boff_nxt = cur_boff + 32'd1;
        if (cur_boff == 32'd1 && {data_byte, off_r[7:0]} != bgpd_pkg::BMP_SIG)
          err = bgpd_pkg::ST_NOT_BM;
        if (cur_boff == 32'd17 && {data_byte, info_r[23:0]} < 32'(bgpd_pkg::MIN_INFO))
          err = bgpd_pkg::ST_HDR_SMALL;
        if (cur_boff == 32'(bgpd_pkg::HDR_LAST)) begin
          err = hdr_err;
          if (hdr_err == bgpd_pkg::ST_PIXEL) begin
            pcnt_nxt  = (bpp_r == 16'd8) ? CW'(n32) : '0;
            bpp24_nxt = (bpp_r == 16'd24);
            bup_nxt   = (height_r == 32'(IMG_SIDE));
            phase_nxt = (off_r == 32'(bgpd_pkg::PIX_BASE)) ? PH_PIXELS : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if ({2'b00, p[31:2]} < 32'(pcnt_r) && p[1:0] != 2'd3) palwr = 1'b1;
        if (cur_boff + 32'd1 == off_r) phase_nxt = PH_PIXELS;
        boff_nxt = cur_boff + 32'd1;
      end
      PH_PIXELS: begin
        if (!bpp24_r && cur_pos < PW'(RAW8)) begin
          pix = 1'b1;
          pix_item.kind    = bgpd_pkg::K_PIX8;
          pix_item.d0      = data_byte;
          pix_item.use_pal = CW'(data_byte) < pcnt_r;
          col_nxt = RW'(cur_col + 1'b1);
        end else if (bpp24_r && cur_pos < PW'(RAW24)) begin
          unique case (cur_lane)
            2'd0: begin
              bg_nxt[7:0] = data_byte;
              lane_nxt    = 2'd1;
            end
            2'd1: begin
              bg_nxt[15:8] = data_byte;
              lane_nxt     = 2'd2;
            end
            default: begin
              pix = 1'b1;
              pix_item.kind = bgpd_pkg::K_PIX24;
              pix_item.d0   = bg_r[7:0];
              pix_item.d1   = bg_r[15:8];
              pix_item.d2   = data_byte;
              lane_nxt = 2'd0;
              col_nxt  = RW'(cur_col + 1'b1);
            end
          endcase
        end
        pos_nxt = pos_inc;
        if ((bpp24_r && pos_inc == PW'(STRIDE24)) || (!bpp24_r && pos_inc == PW'(STRIDE8))) begin
          pos_nxt  = '0;
          col_nxt  = '0;
          lane_nxt = 2'd0;
          row_nxt  = RW'(cur_row + 1'b1);
          if (RW'(cur_row + 1'b1) == RW'(IMG_SIDE)) phase_nxt = PH_IDLE;
        end
      end
      default: ;
    endcase
    if (cur_phase != PH_IDLE) begin
      if (err == bgpd_pkg::ST_PIXEL && end_of_file && phase_nxt != PH_IDLE)
        err = bgpd_pkg::ST_TRUNC;
      if (end_of_file || err != bgpd_pkg::ST_PIXEL) phase_nxt = PH_IDLE;
    end
  end

  // One beat out per byte at most: status wins over pixel over palette write
  always_comb begin
    item = pix_item;
    push = 1'b0;
    if (err != bgpd_pkg::ST_PIXEL) begin
      item        = '0;
      item.kind   = bgpd_pkg::K_STATUS;
      item.status = err;
      push        = accept;
    end else if (pix) begin
      push = accept;
    end else if (palwr) begin
      item      = '0;
      item.kind = bgpd_pkg::K_PALWR;
      item.d0   = data_byte;
      item.d1   = p[9:2];
      item.lane = p[1:0];
      push      = accept;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      boff_r  <= '0;
      pos_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      lane_r  <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      boff_r  <= boff_nxt;
      pos_r   <= pos_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bg_r    <= bg_nxt;
      pcnt_r  <= pcnt_nxt;
      bpp24_r <= bpp24_nxt;
      bup_r   <= bup_nxt;
      if (cur_phase == PH_HEADER) begin
        unique case (cur_boff)
          32'd0:  off_r[7:0]     <= data_byte;
          32'd1:  off_r[15:8]    <= data_byte;
          32'd10: off_r[7:0]     <= data_byte;
          32'd11: off_r[15:8]    <= data_byte;
          32'd12: off_r[23:16]   <= data_byte;
          32'd13: off_r[31:24]   <= data_byte;
          32'd14: info_r[7:0]    <= data_byte;
          32'd15: info_r[15:8]   <= data_byte;
          32'd16: info_r[23:16]  <= data_byte;
          32'd17: info_r[31:24]  <= data_byte;
          32'd18: width_r[7:0]   <= data_byte;
          32'd19: width_r[15:8]  <= data_byte;
          32'd20: width_r[23:16] <= data_byte;
          32'd21: width_r[31:24] <= data_byte;
          32'd22: height_r[7:0]  <= data_byte;
          32'd23: height_r[15:8] <= data_byte;
          32'd24: height_r[23:16] <= data_byte;
          32'd25: height_r[31:24] <= data_byte;
          32'd26: planes_r[7:0]  <= data_byte;
          32'd27: planes_r[15:8] <= data_byte;
          32'd28: bpp_r[7:0]     <= data_byte;
          32'd29: bpp_r[15:8]    <= data_byte;
          32'd30: comp_r[7:0]    <= data_byte;
          32'd31: comp_r[15:8]   <= data_byte;
          32'd32: comp_r[23:16]  <= data_byte;
          32'd33: comp_r[31:24]  <= data_byte;
          32'd46: colors_r[7:0]  <= data_byte;
          32'd47: colors_r[15:8] <= data_byte;
          32'd48: colors_r[23:16] <= data_byte;
          32'd49: colors_r[31:24] <= data_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

/* sv/bgpd_queue.sv */
// Short FIFO of classified items between parser and pixel back end.
module bgpd_queue #(
  parameter int DEPTH = bgpd_pkg::QDEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  bgpd_pkg::item_t push_item,
  input  logic            pop,
  output bgpd_pkg::item_t head,
  output logic            empty,
  output logic            full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bgpd_pkg::item_t   slot_r [DEPTH];
  logic [AW-1:0]     wp_r, rp_r;
  logic [CW-1:0]     count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : AW'(wp_r + 1'b1);
      if (pop)  rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : AW'(rp_r + 1'b1);
      if (push && !pop) count_r <= CW'(count_r + 1'b1);
      else if (pop && !push) count_r <= CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue underflow");
`endif

endmodule

/* sv/bgpd_back.sv */
// Palette memory, luminance pipeline and output register.
module bgpd_back #(
  parameter int PALETTE_DEPTH = bgpd_pkg::PAL_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            invert_gray,
  input  bgpd_pkg::item_t head,
  input  logic            empty,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [3:0]      out_status,
  output logic [4:0]      out_row,
  output logic [4:0]      out_col,
  output logic [7:0]      out_gray,
  output logic            out_last
);

  localparam int AW = $clog2(PALETTE_DEPTH);

  logic [7:0]      mem_b [PALETTE_DEPTH];
  logic [7:0]      mem_g [PALETTE_DEPTH];
  logic [7:0]      mem_r [PALETTE_DEPTH];
  logic [7:0]      rd_b_r, rd_g_r, rd_r_r;
  bgpd_pkg::item_t s1_r, s2_r;
  logic            s1_v_r, s2_v_r, en;
  logic [7:0]      sel_r, sel_g, sel_b;
  logic [21:0]     pr_r;
  logic [23:0]     pg_r;
  logic [20:0]     pb_r;
  logic [24:0]     sum;
  logic [7:0]      gray;

  // Advance the whole pipe unless a finished beat is stuck at the output
  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_ff @(posedge clk) begin
    if (pop) begin
      if (head.kind == bgpd_pkg::K_PALWR) begin
        if (head.lane == 2'd0) mem_b[AW'(head.d1)] <= head.d0;
        if (head.lane == 2'd1) mem_g[AW'(head.d1)] <= head.d0;
        if (head.lane == 2'd2) mem_r[AW'(head.d1)] <= head.d0;
      end else begin
        rd_b_r <= mem_b[AW'(head.d0)];
        rd_g_r <= mem_g[AW'(head.d0)];
        rd_r_r <= mem_r[AW'(head.d0)];
      end
    end
  end

  always_comb begin
    if (s1_r.kind == bgpd_pkg::K_PIX24) begin
      sel_b = s1_r.d0;
      sel_g = s1_r.d1;
      sel_r = s1_r.d2;
    end else begin
      sel_b = rd_b_r;
      sel_g = rd_g_r;
      sel_r = rd_r_r;
    end
  end

  assign sum  = 25'(pr_r) + 25'(pg_r) + 25'(pb_r) + bgpd_pkg::LUMA_RND;
  // Raw index stands for itself when it lies outside the palette
  assign gray = (s2_r.kind == bgpd_pkg::K_PIX8 && !s2_r.use_pal) ? s2_r.d0 : sum[23:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_v_r    <= pop;
      s2_v_r    <= s1_v_r;
      out_valid <= s2_v_r && s2_r.kind != bgpd_pkg::K_PALWR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= head;
      s2_r <= s1_r;
      pr_r <= 22'(sel_r) * bgpd_pkg::LUMA_R;
      pg_r <= 24'(sel_g) * bgpd_pkg::LUMA_G;
      pb_r <= 21'(sel_b) * bgpd_pkg::LUMA_B;
      out_status <= s2_r.status;
      out_row    <= s2_r.row;
      out_col    <= s2_r.col;
      out_last   <= s2_r.last;
      if (s2_r.kind == bgpd_pkg::K_STATUS) out_gray <= 8'd0;
      else out_gray <= invert_gray ? 8'd255 - gray : gray;
    end
  end

`ifndef SYNTHESIS
  a_status_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bgpd_pkg::ST_PIXEL) |->
      (out_row == 5'd0 && out_col == 5'd0 && out_gray == 8'd0 && !out_last))
    else $error("status beat carries pixel data");
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !pop)
    else $error("queue popped while output stalled");
`endif

endmodule

/* sv/bmp_gray_pixel_decoder.sv */
// BMP byte stream to 8-bit gray pixel decoder, top level.
// Usage:
//  - in_*: one file byte per beat; in_tuser marks the first byte of a new file,
//    in_tlast the final byte. A byte is taken every cycle while the item queue
//    has room.
//  - out_*: one beat per pixel (status 0, row, column, gray, tlast on the final
//    pixel) or a single status beat on a header error or truncation; later
//    bytes of that file are dropped until in_tuser.
//  - cfg_*: one-bit invert_gray register, always ready; write only when idle.
// Path: a byte that makes a result reaches out_tvalid through the queue, the
// palette read and multiply stages and the output register.
// Throughput: one byte per cycle while the queue is not full; header and palette
// bytes give no beat. 8 bpp palette entries live in a PALETTE_DEPTH-entry memory
// (256 by default), read in the cycle a pixel index leaves the queue.
// Reset: parser back to the header phase, queue and pipeline empty, inversion
// off; the palette memory is not cleared.
// Stall: when out_tready is low the back end holds, the queue fills, and then
// in_tready drops.
module bmp_gray_pixel_decoder #(
  parameter int IMG_SIDE      = bgpd_pkg::IMG_SIDE_DEF,
  parameter int PALETTE_DEPTH = bgpd_pkg::PAL_DEPTH_DEF,
  parameter int QUEUE_DEPTH   = bgpd_pkg::QDEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] first_byte
  input  logic        in_tlast,   // end_of_file
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [3:0] status, [8:4] row, [13:9] column, [21:14] gray
  output logic        out_tlast,  // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data    // invert_gray
);

  logic            accept, push, pop, empty, full, invert_r;
  bgpd_pkg::item_t f_item, head;
  logic [3:0]      o_status;
  logic [4:0]      o_row, o_col;
  logic [7:0]      o_gray;

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) invert_r <= 1'b0;
    else if (cfg_valid) invert_r <= cfg_data;
  end

  bgpd_front #(.IMG_SIDE(IMG_SIDE), .PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
    .clk(clk), .rst_n(rst_n), .accept(accept), .data_byte(in_tdata),
    .first_byte(in_tuser), .end_of_file(in_tlast), .push(push), .item(f_item)
  );

  bgpd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(f_item), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  bgpd_back #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .invert_gray(invert_r), .head(head), .empty(empty),
    .pop(pop), .out_valid(out_tvalid), .out_ready(out_tready),
    .out_status(o_status), .out_row(o_row), .out_col(o_col), .out_gray(o_gray),
    .out_last(out_tlast)
  );

  assign out_tdata = {2'b00, o_gray, o_col, o_row, o_status};

endmodule
